// ===== hw/rtl/ppi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types and codes for the three-port parallel interface.
// ----------------------------------------------------------------------------
package ppi_pkg;

  // request codes
  localparam logic [2:0] REQ_READ   = 3'd0;
  localparam logic [2:0] REQ_WRITE  = 3'd1;
  localparam logic [2:0] REQ_STB_A  = 3'd2;
  localparam logic [2:0] REQ_STB_B  = 3'd3;
  localparam logic [2:0] REQ_DONE_A = 3'd4;
  localparam logic [2:0] REQ_DONE_B = 3'd5;

  // register offsets
  localparam logic [1:0] SEL_PORT_A = 2'd0;
  localparam logic [1:0] SEL_PORT_B = 2'd1;
  localparam logic [1:0] SEL_PORT_C = 2'd2;
  localparam logic [1:0] SEL_CTRL   = 2'd3;

  // handshake status bits
  localparam logic [7:0] ST_IRQB = 8'h01;
  localparam logic [7:0] ST_BUFB = 8'h02;
  localparam logic [7:0] ST_IENB = 8'h04;
  localparam logic [7:0] ST_IRQA = 8'h08;
  localparam logic [7:0] ST_IEAI = 8'h10;
  localparam logic [7:0] ST_IBFA = 8'h20;
  localparam logic [7:0] ST_IEAO = 8'h40;
  localparam logic [7:0] ST_OBEA = 8'h80;

  // port C bits taken over by status, per mode
  localparam logic [7:0] MASK_A_BIDIR = 8'hF8;
  localparam logic [7:0] MASK_A_IN    = 8'h38;
  localparam logic [7:0] MASK_A_OUT   = 8'hC8;
  localparam logic [7:0] MASK_B       = 8'h07;
  localparam logic [7:0] HI_NIB       = 8'hF0;
  localparam logic [7:0] LO_NIB       = 8'h0F;

  localparam logic [7:0] MODE_RESET = 8'h9B;

  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] reg_sel;
    logic [7:0] data_in;
    logic [7:0] pins_a;
    logic [7:0] pins_b;
    logic [7:0] pins_c;
  } ppi_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] port_a_out;
    logic [7:0] port_b_out;
    logic [7:0] port_c_out;
    logic       out_event_a;
    logic       out_event_b;
    logic       out_event_c;
    logic       read_ack_a;
    logic       read_ack_b;
    logic       irq_a;
    logic       irq_b;
  } ppi_result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ppi_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_if
// Valid/ready channels carrying request words and result words.
// ----------------------------------------------------------------------------
interface ppi_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [1:0] reg_sel;
  logic [7:0] data_in;
  logic [7:0] pins_a;
  logic [7:0] pins_b;
  logic [7:0] pins_c;

  modport source (output valid, req_type, reg_sel, data_in, pins_a, pins_b, pins_c,
                  input ready);
  modport sink (input valid, req_type, reg_sel, data_in, pins_a, pins_b, pins_c,
                output ready);
endinterface

interface ppi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] port_a_out;
  logic [7:0] port_b_out;
  logic [7:0] port_c_out;
  logic       out_event_a;
  logic       out_event_b;
  logic       out_event_c;
  logic       read_ack_a;
  logic       read_ack_b;
  logic       irq_a;
  logic       irq_b;

  modport source (output valid, read_data, port_a_out, port_b_out, port_c_out,
                  out_event_a, out_event_b, out_event_c, read_ack_a, read_ack_b,
                  irq_a, irq_b,
                  input ready);
  modport sink (input valid, read_data, port_a_out, port_b_out, port_c_out,
                out_event_a, out_event_b, out_event_c, read_ack_a, read_ack_b,
                irq_a, irq_b,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/programmable_parallel_port_interface_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// programmable_parallel_port_interface_top
// Three-port parallel interface: request register, step logic, result register.
// ----------------------------------------------------------------------------
// A word passes the request register, a ppi_core step and the result register;
// ppi_core updates state once per step. Throughput: one word per cycle while
// out_ch takes results; a waiting result still lets one more word in.
// Reset (rst_n low, synchronous): mode word 0x9B (all ports input), status and
// all latches zero, request and result registers empty.
module programmable_parallel_port_interface_top (
  input  logic      clk,
  input  logic      rst_n,
  ppi_in_if.sink    in_ch,
  ppi_out_if.source out_ch
);
  import ppi_pkg::*;

  ppi_item_t   item_r;
  ppi_result_t res_r;
  ppi_result_t step_res;
  logic        stage_valid_r, stage_valid_nxt;
  logic        out_valid_r,   out_valid_nxt;
  logic        advance;
  logic        in_ready;
  logic        in_take;

  // handshake control
  assign advance  = stage_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !stage_valid_r || advance;
  assign in_take  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_take)      stage_valid_nxt = 1'b1;
    else if (advance) stage_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (advance)           out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.req_type <= in_ch.req_type;
      item_r.reg_sel  <= in_ch.reg_sel;
      item_r.data_in  <= in_ch.data_in;
      item_r.pins_a   <= in_ch.pins_a;
      item_r.pins_b   <= in_ch.pins_b;
      item_r.pins_c   <= in_ch.pins_c;
    end
  end

  // step logic and state
  ppi_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .result  (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = res_r.read_data;
  assign out_ch.port_a_out  = res_r.port_a_out;
  assign out_ch.port_b_out  = res_r.port_b_out;
  assign out_ch.port_c_out  = res_r.port_c_out;
  assign out_ch.out_event_a = res_r.out_event_a;
  assign out_ch.out_event_b = res_r.out_event_b;
  assign out_ch.out_event_c = res_r.out_event_c;
  assign out_ch.read_ack_a  = res_r.read_ack_a;
  assign out_ch.read_ack_b  = res_r.read_ack_b;
  assign out_ch.irq_a       = res_r.irq_a;
  assign out_ch.irq_b       = res_r.irq_b;

  // a stepped word always shows up as a result
  a_step_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("stepped word did not reach the result register");

  // full request register and stalled result hold off new words
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r && out_valid_r && !out_ch.ready |-> !in_ready)
    else $error("new word taken while both registers are full");

  // an accepted word lands in the request register
  a_take_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> stage_valid_r)
    else $error("accepted word not held in the request register");

endmodule
`default_nettype wire

// ===== hw/rtl/ppi_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_core
// Mode, latches and handshake status; one request word handled per step.
// ----------------------------------------------------------------------------
module ppi_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  ppi_pkg::ppi_item_t item,
  output ppi_pkg::ppi_result_t result
);
  import ppi_pkg::*;

  logic [7:0] mode_r,   mode_nxt;
  logic [7:0] status_r, status_nxt;
  logic [7:0] in_a_r,   in_a_nxt;
  logic [7:0] out_a_r,  out_a_nxt;
  logic [7:0] in_b_r,   in_b_nxt;
  logic [7:0] out_b_r,  out_b_nxt;
  logic [7:0] out_c_r,  out_c_nxt;

  logic a_bidir, a_simple, a_input, cu_input, b_strobe, b_input, cl_input;
  logic [7:0] st_mask;
  logic [7:0] st_work;
  logic [7:0] bit_sel;
  logic [7:0] pc_view;
  logic       irq_go;

  // port C bits that show status in a given mode
  function automatic logic [7:0] mask_of(input logic [7:0] m);
    logic [7:0] k;
    k = 8'h00;
    if (m[6]) begin
      k = MASK_A_BIDIR;
    end else if (m[6:5] == 2'b01) begin
      k = m[4] ? MASK_A_IN : MASK_A_OUT;
    end
    if (m[2]) begin
      k = k | MASK_B;
    end
    return k;
  endfunction

  // recompute interrupt bits from enables and buffer flags
  function automatic logic [7:0] irq_fix(input logic [7:0] s, input logic [7:0] m);
    logic [7:0] t;
    logic       in_a;
    logic       out_a;
    logic       r;
    t     = s;
    in_a  = ((s & ST_IEAI) != 8'h00) && ((s & ST_IBFA) != 8'h00);
    out_a = ((s & ST_IEAO) != 8'h00) && ((s & ST_OBEA) != 8'h00);
    if (m[6] || (m[6:5] == 2'b01)) begin
      if (m[6]) r = in_a || out_a;
      else      r = m[4] ? in_a : out_a;
      t = r ? (t | ST_IRQA) : (t & ~ST_IRQA);
    end
    if (m[2]) begin
      r = ((t & ST_IENB) != 8'h00) && ((t & ST_BUFB) != 8'h00);
      t = r ? (t | ST_IRQB) : (t & ~ST_IRQB);
    end
    return t;
  endfunction

  // mode decode
  assign a_bidir  = mode_r[6];
  assign a_simple = (mode_r[6:5] == 2'b00);
  assign a_input  = mode_r[4];
  assign cu_input = mode_r[3];
  assign b_strobe = mode_r[2];
  assign b_input  = mode_r[1];
  assign cl_input = mode_r[0];
  assign st_mask  = mask_of(mode_r);
  assign bit_sel  = 8'h01 << item.data_in[3:1];

  // port C pins merged with output latch halves
  always_comb begin
    pc_view = item.pins_c;
    if (!cl_input) pc_view = (pc_view & HI_NIB) | (out_c_r & LO_NIB);
    if (!cu_input) pc_view = (pc_view & LO_NIB) | (out_c_r & HI_NIB);
  end

  // request handling
  always_comb begin
    mode_nxt   = mode_r;
    st_work    = status_r;
    in_a_nxt   = in_a_r;
    out_a_nxt  = out_a_r;
    in_b_nxt   = in_b_r;
    out_b_nxt  = out_b_r;
    out_c_nxt  = out_c_r;
    irq_go     = 1'b0;
    result     = '0;
    case (item.req_type)
      REQ_READ: begin
        case (item.reg_sel)
          SEL_PORT_A: begin
            if (!a_input && !a_bidir) begin
              result.read_data = out_a_r;
            end else if (a_simple) begin
              in_a_nxt         = item.pins_a;
              result.read_data = item.pins_a;
            end else begin
              st_work           = st_work & ~ST_IBFA;
              irq_go            = 1'b1;
              result.read_ack_a = 1'b1;
              result.read_data  = in_a_r;
            end
          end
          SEL_PORT_B: begin
            if (!b_input) begin
              result.read_data = out_b_r;
            end else if (!b_strobe) begin
              in_b_nxt         = item.pins_b;
              result.read_data = item.pins_b;
            end else begin
              st_work           = st_work & ~ST_BUFB;
              irq_go            = 1'b1;
              result.read_ack_b = 1'b1;
              result.read_data  = in_b_r;
            end
          end
          SEL_PORT_C: begin
            result.read_data = (status_r & st_mask) | (pc_view & ~st_mask);
          end
          default: begin
            result.read_data = mode_r | 8'h80;
          end
        endcase
      end
      REQ_WRITE: begin
        case (item.reg_sel)
          SEL_PORT_A: begin
            out_a_nxt = item.data_in;
            if (!a_input || a_bidir) begin
              result.out_event_a = 1'b1;
              if (!a_simple) begin
                st_work = st_work & ~ST_OBEA;
                irq_go  = 1'b1;
              end
            end
          end
          SEL_PORT_B: begin
            out_b_nxt = item.data_in;
            if (!b_input) begin
              result.out_event_b = 1'b1;
              if (b_strobe) begin
                st_work = st_work & ~ST_BUFB;
                irq_go  = 1'b1;
              end
            end
          end
          SEL_PORT_C: begin
            out_c_nxt          = item.data_in;
            result.out_event_c = !(cu_input && cl_input);
          end
          default: begin
            if (item.data_in[7]) begin
              // new mode clears output latches and status; interrupts come out clear
              mode_nxt  = item.data_in;
              out_a_nxt = 8'h00;
              out_b_nxt = 8'h00;
              out_c_nxt = 8'h00;
              st_work   = 8'h00;
            end else if ((st_mask & bit_sel) != 8'h00) begin
              st_work = item.data_in[0] ? (st_work | bit_sel) : (st_work & ~bit_sel);
              irq_go  = 1'b1;
            end else begin
              out_c_nxt = item.data_in[0] ? (out_c_r | bit_sel) : (out_c_r & ~bit_sel);
              result.out_event_c = !((cu_input && ((bit_sel & HI_NIB) != 8'h00)) ||
                                     (cl_input && ((bit_sel & LO_NIB) != 8'h00)));
            end
          end
        endcase
      end
      REQ_STB_A: begin
        if (!a_simple) begin
          in_a_nxt = item.data_in;
          if (a_input || a_bidir) begin
            st_work = st_work | ST_IBFA;
            irq_go  = 1'b1;
          end
        end
      end
      REQ_STB_B: begin
        if (b_strobe) begin
          in_b_nxt = item.data_in;
          if (b_input) begin
            st_work = st_work | ST_BUFB;
            irq_go  = 1'b1;
          end
        end
      end
      REQ_DONE_A: begin
        if (!a_simple && (!a_input || a_bidir)) begin
          st_work = st_work | ST_OBEA;
          irq_go  = 1'b1;
        end
      end
      REQ_DONE_B: begin
        if (b_strobe && !b_input) begin
          st_work = st_work | ST_BUFB;
          irq_go  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    status_nxt        = irq_go ? irq_fix(st_work, mode_r) : st_work;
    result.port_a_out = out_a_nxt;
    result.port_b_out = out_b_nxt;
    result.port_c_out = out_c_nxt;
    result.irq_a      = (status_nxt & ST_IRQA) != 8'h00;
    result.irq_b      = (status_nxt & ST_IRQB) != 8'h00;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RESET;
      status_r <= 8'h00;
      in_a_r   <= 8'h00;
      out_a_r  <= 8'h00;
      in_b_r   <= 8'h00;
      out_b_r  <= 8'h00;
      out_c_r  <= 8'h00;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      status_r <= status_nxt;
      in_a_r   <= in_a_nxt;
      out_a_r  <= out_a_nxt;
      in_b_r   <= in_b_nxt;
      out_b_r  <= out_b_nxt;
      out_c_r  <= out_c_nxt;
    end
  end

  // mode words always carry the mode-set flag
  a_mode_flag: assert property (@(posedge clk) disable iff (!rst_n) mode_r[7])
    else $error("mode word lost its mode-set flag");

  // status bits only live where the mode gives them a meaning
  a_status_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r & ~mask_of(mode_r)) == 8'h00)
    else $error("status bit set outside the mode's status mask");

  // a new mode leaves clean status and port C latch
  a_mode_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (item.req_type == REQ_WRITE) && (item.reg_sel == SEL_CTRL) &&
    item.data_in[7] |=> (status_r == 8'h00) && (out_c_r == 8'h00))
    else $error("mode write did not clear status or port C latch");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the three-port parallel interface word by word. Bus accesses, strobes
// and output-done events are sent over the request channel, with random gaps.
// The port logic's behavioral copy, or a typed script row, gives the expected
// result word for each request. Each returned word is compared field by field,
// and the result side stalls at random too. A short directed script runs first,
// then about 1200 random requests that mostly build on mode words.
// ----------------------------------------------------------------------------
module testbench;
  import ppi_pkg::*;

  localparam int         HALF_PERIOD = 5;
  localparam int         NUM_RANDOM  = 1200;
  localparam int         DRAIN_WAIT  = 8;
  localparam int         LONG_HOLD   = 80;
  // request codes the block does not know
  localparam logic [2:0] REQ_UNK_LO  = 3'd6;
  localparam logic [2:0] REQ_UNK_HI  = 3'd7;
  // control byte bit 7: mode word rather than port C bit set/reset
  localparam logic [7:0] MODE_FLAG   = 8'h80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ppi_in_if  in_ch ();
  ppi_out_if out_ch ();

  programmable_parallel_port_interface_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // directed script rows
  typedef struct {
    ppi_item_t   item;
    bit          typed;
    ppi_result_t want;
  } script_row_t;

  script_row_t script[$];
  ppi_result_t awaited_words[$];
  int          mismatches = 0;

  // port state as the block should hold it
  logic [7:0] mode_q;
  logic [7:0] stat_q;
  logic [7:0] in_a_q;
  logic [7:0] out_a_q;
  logic [7:0] in_b_q;
  logic [7:0] out_b_q;
  logic [7:0] out_c_q;

  // mode word decode
  function automatic bit a_bidir();
    return mode_q[6];
  endfunction

  function automatic bit a_strobed();
    return mode_q[6:5] == 2'b01;
  endfunction

  function automatic bit a_simple();
    return mode_q[6:5] == 2'b00;
  endfunction

  function automatic bit a_in();
    return mode_q[4];
  endfunction

  function automatic bit cu_in();
    return mode_q[3];
  endfunction

  function automatic bit b_strobed();
    return mode_q[2];
  endfunction

  function automatic bit b_in();
    return mode_q[1];
  endfunction

  function automatic bit cl_in();
    return mode_q[0];
  endfunction

  // port C bits owned by handshake status in the current mode
  function automatic logic [7:0] status_window();
    logic [7:0] m;
    m = 8'h00;
    if (a_bidir()) begin
      m |= MASK_A_BIDIR;
    end else if (a_strobed()) begin
      m |= a_in() ? MASK_A_IN : MASK_A_OUT;
    end
    if (b_strobed()) m |= MASK_B;
    return m;
  endfunction

  // recompute INTR A / INTR B from enables and buffer flags
  task automatic refresh_intr();
    bit in_a;
    bit out_a;
    bit hit;
    in_a  = ((stat_q & ST_IEAI) != 0) && ((stat_q & ST_IBFA) != 0);
    out_a = ((stat_q & ST_IEAO) != 0) && ((stat_q & ST_OBEA) != 0);
    if (a_bidir() || a_strobed()) begin
      if (a_bidir()) hit = in_a || out_a;
      else hit = a_in() ? in_a : out_a;
      stat_q = hit ? (stat_q | ST_IRQA) : (stat_q & ~ST_IRQA);
    end
    if (b_strobed()) begin
      hit = ((stat_q & ST_IENB) != 0) && ((stat_q & ST_BUFB) != 0);
      stat_q = hit ? (stat_q | ST_IRQB) : (stat_q & ~ST_IRQB);
    end
  endtask

  // apply one request to the port state and form its result word
  task automatic advance_ppi(input ppi_item_t it, output ppi_result_t r);
    logic [7:0] cv;
    logic [7:0] m;
    logic [7:0] bitv;
    r = '0;
    case (it.req_type)
      REQ_READ: begin
        case (it.reg_sel)
          SEL_PORT_A: begin
            if (!a_in() && !a_bidir()) begin
              r.read_data = out_a_q;
            end else begin
              if (a_simple()) begin
                in_a_q = it.pins_a;
              end else begin
                stat_q &= ~ST_IBFA;
                refresh_intr();
                r.read_ack_a = 1'b1;
              end
              r.read_data = in_a_q;
            end
          end
          SEL_PORT_B: begin
            if (!b_in()) begin
              r.read_data = out_b_q;
            end else begin
              if (!b_strobed()) begin
                in_b_q = it.pins_b;
              end else begin
                stat_q &= ~ST_BUFB;
                refresh_intr();
                r.read_ack_b = 1'b1;
              end
              r.read_data = in_b_q;
            end
          end
          SEL_PORT_C: begin
            // pins for input halves, latch for output halves, status on top
            cv = it.pins_c;
            m  = status_window();
            if (!cl_in()) cv = (cv & HI_NIB) | (out_c_q & LO_NIB);
            if (!cu_in()) cv = (cv & LO_NIB) | (out_c_q & HI_NIB);
            r.read_data = (stat_q & m) | (cv & ~m);
          end
          default: begin
            r.read_data = mode_q | MODE_FLAG;
          end
        endcase
      end
      REQ_WRITE: begin
        case (it.reg_sel)
          SEL_PORT_A: begin
            out_a_q = it.data_in;
            if (!a_in() || a_bidir()) begin
              r.out_event_a = 1'b1;
              if (!a_simple()) begin
                stat_q &= ~ST_OBEA;
                refresh_intr();
              end
            end
          end
          SEL_PORT_B: begin
            out_b_q = it.data_in;
            if (!b_in()) begin
              r.out_event_b = 1'b1;
              if (b_strobed()) begin
                stat_q &= ~ST_BUFB;
                refresh_intr();
              end
            end
          end
          SEL_PORT_C: begin
            out_c_q = it.data_in;
            if (!(cu_in() && cl_in())) r.out_event_c = 1'b1;
          end
          default: begin
            if ((it.data_in & MODE_FLAG) != 0) begin
              // new mode word clears output latches and status
              mode_q  = it.data_in;
              out_a_q = 8'h00;
              out_b_q = 8'h00;
              out_c_q = 8'h00;
              stat_q  = 8'h00;
              refresh_intr();
            end else begin
              // single bit set/reset: status bit or port C latch bit
              bitv = 8'h01 << it.data_in[3:1];
              if ((status_window() & bitv) != 0) begin
                stat_q = it.data_in[0] ? (stat_q | bitv) : (stat_q & ~bitv);
                refresh_intr();
              end else begin
                out_c_q = it.data_in[0] ? (out_c_q | bitv) : (out_c_q & ~bitv);
                r.out_event_c = !((cu_in() && ((bitv & HI_NIB) != 0)) ||
                                  (cl_in() && ((bitv & LO_NIB) != 0)));
              end
            end
          end
        endcase
      end
      REQ_STB_A: begin
        if (!a_simple()) begin
          in_a_q = it.data_in;
          if (a_in() || a_bidir()) begin
            stat_q |= ST_IBFA;
            refresh_intr();
          end
        end
      end
      REQ_STB_B: begin
        if (b_strobed()) begin
          in_b_q = it.data_in;
          if (b_in()) begin
            stat_q |= ST_BUFB;
            refresh_intr();
          end
        end
      end
      REQ_DONE_A: begin
        if (!a_simple() && (!a_in() || a_bidir())) begin
          stat_q |= ST_OBEA;
          refresh_intr();
        end
      end
      REQ_DONE_B: begin
        if (b_strobed() && !b_in()) begin
          stat_q |= ST_BUFB;
          refresh_intr();
        end
      end
      default: ;
    endcase
    r.port_a_out = out_a_q;
    r.port_b_out = out_b_q;
    r.port_c_out = out_c_q;
    r.irq_a      = (stat_q & ST_IRQA) != 0;
    r.irq_b      = (stat_q & ST_IRQB) != 0;
  endtask

  function automatic ppi_item_t req_word(logic [2:0] rq, logic [1:0] sl, logic [7:0] d,
                                         logic [7:0] pa, logic [7:0] pb, logic [7:0] pc);
    return {rq, sl, d, pa, pb, pc};
  endfunction

  // ev: events a,b,c; ack: a,b; irq: a,b
  function automatic ppi_result_t outcome(logic [7:0] rd, logic [7:0] pa, logic [7:0] pb,
                                          logic [7:0] pc, logic [2:0] ev, logic [1:0] ack,
                                          logic [1:0] irq);
    return {rd, pa, pb, pc, ev, ack, irq};
  endfunction

  task automatic add_row(input ppi_item_t it, input bit typed, input ppi_result_t want);
    script_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    script.push_back(row);
  endtask

  // wait draw per word, with bursts of back-to-back words
  function automatic int idle_cycles(int seq);
    if ((seq / 64) % 4 == 3) return 0;
    return $urandom_range(0, 9);
  endfunction

  // random request, mostly well-formed traffic for the current mode
  function automatic ppi_item_t random_request();
    ppi_item_t it;
    int        pick;
    it.req_type = REQ_READ;
    it.reg_sel  = 2'($urandom_range(0, 3));
    it.data_in  = 8'($urandom_range(0, 255));
    it.pins_a   = 8'($urandom_range(0, 255));
    it.pins_b   = 8'($urandom_range(0, 255));
    it.pins_c   = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      it.req_type   = REQ_WRITE;
      it.reg_sel    = SEL_CTRL;
      it.data_in[7] = 1'b1;
    end else if (pick < 15) begin
      it.req_type   = REQ_WRITE;
      it.reg_sel    = SEL_CTRL;
      it.data_in[7] = 1'b0;
    end else if (pick < 40) begin
      it.req_type = REQ_READ;
    end else if (pick < 58) begin
      it.req_type = REQ_WRITE;
      it.reg_sel  = 2'($urandom_range(0, 2));
    end else if (pick < 75) begin
      it.req_type = $urandom_range(0, 1) ? REQ_STB_B : REQ_STB_A;
    end else if (pick < 92) begin
      it.req_type = $urandom_range(0, 1) ? REQ_DONE_B : REQ_DONE_A;
    end else if (pick < 96) begin
      it.req_type = $urandom_range(0, 1) ? REQ_UNK_HI : REQ_UNK_LO;
    end else begin
      it.req_type = 3'($urandom_range(0, 7));
    end
    return it;
  endfunction

  // present one request word and hold it until taken
  task automatic offer_word(input ppi_item_t it, input ppi_result_t want, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    awaited_words.push_back(want);
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= it.req_type;
    in_ch.reg_sel  <= it.reg_sel;
    in_ch.data_in  <= it.data_in;
    in_ch.pins_a   <= it.pins_a;
    in_ch.pins_b   <= it.pins_b;
    in_ch.pins_c   <= it.pins_c;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %02h, actual %02h", fname, want, got);
      mismatches++;
    end
  endtask

  task automatic check_word(input ppi_result_t got);
    ppi_result_t want;
    if (awaited_words.size() == 0) begin
      $error("result word arrived with none outstanding");
      mismatches++;
    end else begin
      want = awaited_words.pop_front();
      check_field("read_data", want.read_data, got.read_data);
      check_field("port_a_out", want.port_a_out, got.port_a_out);
      check_field("port_b_out", want.port_b_out, got.port_b_out);
      check_field("port_c_out", want.port_c_out, got.port_c_out);
      check_field("out_event_a", 8'(want.out_event_a), 8'(got.out_event_a));
      check_field("out_event_b", 8'(want.out_event_b), 8'(got.out_event_b));
      check_field("out_event_c", 8'(want.out_event_c), 8'(got.out_event_c));
      check_field("read_ack_a", 8'(want.read_ack_a), 8'(got.read_ack_a));
      check_field("read_ack_b", 8'(want.read_ack_b), 8'(got.read_ack_b));
      check_field("irq_a", 8'(want.irq_a), 8'(got.irq_a));
      check_field("irq_b", 8'(want.irq_b), 8'(got.irq_b));
    end
  endtask

  // request side: reset, directed script, random traffic, drain
  initial begin : request_source
    ppi_result_t pred;
    ppi_item_t   it;
    int          seq;
    int          counted;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= REQ_READ;
    in_ch.reg_sel  <= SEL_PORT_A;
    in_ch.data_in  <= 8'h00;
    in_ch.pins_a   <= 8'h00;
    in_ch.pins_b   <= 8'h00;
    in_ch.pins_c   <= 8'h00;

    mode_q  = MODE_RESET;
    stat_q  = 8'h00;
    in_a_q  = 8'h00;
    out_a_q = 8'h00;
    in_b_q  = 8'h00;
    out_b_q = 8'h00;
    out_c_q = 8'h00;

    // after reset: all ports simple input
    add_row(req_word(REQ_READ, SEL_CTRL, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            outcome(8'h9B, 8'h00, 8'h00, 8'h00, 3'b000, 2'b00, 2'b00));
    add_row(req_word(REQ_READ, SEL_PORT_A, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
            outcome(8'hFF, 8'h00, 8'h00, 8'h00, 3'b000, 2'b00, 2'b00));
    add_row(req_word(REQ_READ, SEL_PORT_B, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            outcome(8'h00, 8'h00, 8'h00, 8'h00, 3'b000, 2'b00, 2'b00));
    add_row(req_word(REQ_READ, SEL_PORT_C, 8'h00, 8'h00, 8'h00, 8'h5A), 1'b1,
            outcome(8'h5A, 8'h00, 8'h00, 8'h00, 3'b000, 2'b00, 2'b00));
    // unknown request changes nothing
    add_row(req_word(REQ_UNK_LO, SEL_CTRL, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
            outcome(8'h00, 8'h00, 8'h00, 8'h00, 3'b000, 2'b00, 2'b00));
    // writes to input ports latch silently
    add_row(req_word(REQ_WRITE, SEL_PORT_A, 8'hFF, 8'h00, 8'h00, 8'h00), 1'b1,
            outcome(8'h00, 8'hFF, 8'h00, 8'h00, 3'b000, 2'b00, 2'b00));
    add_row(req_word(REQ_WRITE, SEL_PORT_C, 8'h3C, 8'h00, 8'h00, 8'h00), 1'b1,
            outcome(8'h00, 8'hFF, 8'h00, 8'h3C, 3'b000, 2'b00, 2'b00));
    // all outputs, simple: new mode clears the latches
    add_row(req_word(REQ_WRITE, SEL_CTRL, 8'h80, 8'h00, 8'h00, 8'h00), 1'b1,
            outcome(8'h00, 8'h00, 8'h00, 8'h00, 3'b000, 2'b00, 2'b00));
    add_row(req_word(REQ_WRITE, SEL_PORT_B, 8'hFF, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    add_row(req_word(REQ_WRITE, SEL_CTRL, 8'h0F, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    add_row(req_word(REQ_READ, SEL_PORT_C, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    // strobed A and B, both inputs, with interrupts enabled
    add_row(req_word(REQ_WRITE, SEL_CTRL, 8'hB6, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    add_row(req_word(REQ_WRITE, SEL_CTRL, 8'h09, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    add_row(req_word(REQ_WRITE, SEL_CTRL, 8'h05, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    add_row(req_word(REQ_STB_A, SEL_PORT_A, 8'h77, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    add_row(req_word(REQ_STB_B, SEL_PORT_B, 8'h88, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    add_row(req_word(REQ_READ, SEL_PORT_C, 8'h00, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
    add_row(req_word(REQ_READ, SEL_PORT_A, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    // bidirectional A with strobed output B
    add_row(req_word(REQ_WRITE, SEL_CTRL, 8'hC4, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    add_row(req_word(REQ_WRITE, SEL_CTRL, 8'h0D, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    add_row(req_word(REQ_WRITE, SEL_PORT_A, 8'h11, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    add_row(req_word(REQ_DONE_A, SEL_PORT_A, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    add_row(req_word(REQ_STB_A, SEL_PORT_A, 8'h99, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    add_row(req_word(REQ_STB_B, SEL_PORT_B, 8'h42, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    add_row(req_word(REQ_READ, SEL_PORT_C, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    // strobed A output, simple B ignores strobes
    add_row(req_word(REQ_WRITE, SEL_CTRL, 8'hA0, 8'h00, 8'h00, 8'h00), 1'b0, '0);
    add_row(req_word(REQ_STB_B, SEL_PORT_B, 8'hFF, 8'h00, 8'h00, 8'h00), 1'b0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    seq = 0;
    foreach (script[i]) begin
      advance_ppi(script[i].item, pred);
      offer_word(script[i].item, script[i].typed ? script[i].want : pred, idle_cycles(seq));
      seq++;
    end

    counted = 0;
    while (counted < NUM_RANDOM) begin
      it = random_request();
      advance_ppi(it, pred);
      offer_word(it, pred, idle_cycles(seq));
      seq++;
      if (it.req_type <= REQ_DONE_B) counted++;
    end
    in_ch.valid <= 1'b0;

    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // result side: random stalls plus long holds that back up the block
  initial begin : result_sink
    ppi_result_t got;
    int          stall_left;
    int          hold_left;
    int          taken;
    stall_left = 0;
    hold_left  = 0;
    taken      = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (out_ch.valid && out_ch.ready) begin
        got.read_data   = out_ch.read_data;
        got.port_a_out  = out_ch.port_a_out;
        got.port_b_out  = out_ch.port_b_out;
        got.port_c_out  = out_ch.port_c_out;
        got.out_event_a = out_ch.out_event_a;
        got.out_event_b = out_ch.out_event_b;
        got.out_event_c = out_ch.out_event_c;
        got.read_ack_a  = out_ch.read_ack_a;
        got.read_ack_b  = out_ch.read_ack_b;
        got.irq_a       = out_ch.irq_a;
        got.irq_b       = out_ch.irq_b;
        check_word(got);
        taken++;
        stall_left = idle_cycles(taken + 96);
        if (taken == 200 || taken == 700) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // run limit
  initial begin : watchdog
    #(3_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
